[hw/rtl/lsw_pkg.sv]
// Link stall watchdog package: shared types, widths and register codes.
// No dependencies; imported by the RAM user and the checker.
package lsw_pkg;

    localparam int IDX_W     = 2;
    localparam int NOW_W     = 40;
    localparam int GEN_W     = 32;
    localparam int TMO_W     = 32;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [TMO_W-1:0] QUIET_TIMEOUT_RESET = TMO_W'(300000);
    localparam logic [ACT_W-1:0] ACTIVE_LINKS_RESET  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUIET_TIMEOUT = 2'd0,
        CFG_ACTIVE_LINKS  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0] link_index;
        logic [NOW_W-1:0] now_ms;
        logic             can_reconfigure;
        logic             link_active;
        logic             link_connected;
        logic [GEN_W-1:0] link_generation;
    } t_obs;

    typedef struct packed {
        logic [IDX_W-1:0] report_index;
        logic             stall_request;
        logic             now_armed;
    } t_rpt;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

endpackage

[hw/rtl/lsw_stream_if.sv]
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is a parameter; used with the types of lsw_pkg.
interface lsw_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

[hw/rtl/link_stall_watchdog_unit.sv]
// Link stall watchdog: per-link state in lsw_ram, read-modify-write per observation.
// Observation in r_s1, report in r_out; one observation per cycle unless o_rpt stalls.
// Rate is set by the single RAM read port plus a one-entry write forward.
// Reset clears config registers to defaults, entry valid bits, stage and output valids;
// an entry not yet written reads as all-zero state, so no clearing pass is needed.
// Depends on lsw_pkg, lsw_stream_if, lsw_ram.
module link_stall_watchdog_unit
    import lsw_pkg::*;
#(
    parameter int LINK_SLOTS = 4,
    parameter int TIME_BITS  = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsw_stream_if.sink    i_obs,
    lsw_stream_if.source  o_rpt,
    lsw_stream_if.sink    i_cfg
);
    localparam int AW    = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
    localparam int VLD_N = 1 << AW;
    localparam int SW    = 1 + TIME_BITS + GEN_W;
    localparam int EW    = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;
    localparam int CW    = $clog2(LINK_SLOTS + 1) + ACT_W;

    logic [TMO_W-1:0] r_timeout;
    logic [ACT_W-1:0] r_active;

    logic             r_s1_vld;
    t_obs             r_s1;
    logic             r_out_vld;
    t_rpt             r_out;

    logic [VLD_N-1:0] r_ent_vld;
    logic             r_fwd_vld;
    logic [AW-1:0]    r_fwd_addr;
    logic [SW-1:0]    r_fwd_data;

    logic             obs_acc;
    logic             s1_adv;
    logic [AW-1:0]    s1_addr;
    logic [SW-1:0]    rd_data;
    logic [SW-1:0]    cur;
    logic             cur_armed;
    logic [TIME_BITS-1:0] cur_start;
    logic [GEN_W-1:0] cur_gen;
    logic [TIME_BITS-1:0] now_t;
    logic [CW-1:0]    limit;
    logic             in_slot;
    logic             hit;
    logic [EW-1:0]    elapsed;
    logic             nxt_armed;
    logic [TIME_BITS-1:0] nxt_start;
    logic [GEN_W-1:0] nxt_gen;
    logic             stall;
    logic             wr_en;
    logic [SW-1:0]    wr_data;
    t_rpt             n_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= QUIET_TIMEOUT_RESET;
            r_active  <= ACTIVE_LINKS_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.payload.index))
                CFG_QUIET_TIMEOUT: r_timeout <= i_cfg.payload.data[TMO_W-1:0];
                CFG_ACTIVE_LINKS:  r_active  <= i_cfg.payload.data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv       = r_s1_vld && (!r_out_vld || o_rpt.ready);
    assign i_obs.ready  = !r_s1_vld || s1_adv;
    assign obs_acc      = i_obs.valid && i_obs.ready;

    lsw_ram #(
        .WIDTH (SW),
        .DEPTH (LINK_SLOTS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (obs_acc),
        .i_rd_addr (AW'(i_obs.payload.link_index)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        s1_addr = AW'(r_s1.link_index);
        limit   = (CW'(r_active) < CW'(LINK_SLOTS)) ? CW'(r_active) : CW'(LINK_SLOTS);
        in_slot = CW'(r_s1.link_index) < CW'(LINK_SLOTS);
        hit     = (CW'(r_s1.link_index) < limit) && r_s1.can_reconfigure;

        if (r_fwd_vld && (r_fwd_addr == s1_addr)) begin
            cur = r_fwd_data;
        end else if (r_ent_vld[s1_addr]) begin
            cur = rd_data;
        end else begin
            cur = '0;
        end
        cur_armed = cur[SW-1];
        cur_start = cur[GEN_W +: TIME_BITS];
        cur_gen   = cur[GEN_W-1:0];

        now_t   = TIME_BITS'(r_s1.now_ms);
        elapsed = (now_t >= cur_start) ? (EW'(now_t) - EW'(cur_start)) : '0;

        nxt_armed = cur_armed;
        nxt_start = cur_start;
        nxt_gen   = cur_gen;
        stall     = 1'b0;
        if (!r_s1.link_active || r_s1.link_connected) begin
            nxt_armed = 1'b0;
            nxt_start = '0;
            nxt_gen   = r_s1.link_generation;
        end else if (!cur_armed || (r_s1.link_generation != cur_gen)) begin
            nxt_armed = 1'b1;
            nxt_start = now_t;
            nxt_gen   = r_s1.link_generation;
        end else if (elapsed >= EW'(r_timeout)) begin
            stall     = 1'b1;
            nxt_start = now_t;
        end

        wr_en   = s1_adv && hit;
        wr_data = {nxt_armed, nxt_start, nxt_gen};

        n_out.report_index  = r_s1.link_index;
        n_out.stall_request = hit && stall;
        n_out.now_armed     = hit ? nxt_armed : (in_slot && cur_armed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ent_vld <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (i_obs.ready) begin
                r_s1_vld <= i_obs.valid;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_rpt.ready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_ent_vld[s1_addr] <= 1'b1;
                r_fwd_vld          <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (obs_acc) begin
            r_s1 <= i_obs.payload;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
        if (wr_en) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= wr_data;
        end
    end

    assign o_rpt.valid   = r_out_vld;
    assign o_rpt.payload = r_out;
endmodule

[hw/rtl/lsw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[hw/rtl/lsw_checker.sv]
// Port-level checks for link_stall_watchdog_unit, attached by bind below.
// Depends on lsw_pkg.
module lsw_checker
    import lsw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_obs_valid,
    input logic i_obs_ready,
    input logic i_rpt_valid,
    input logic i_rpt_ready,
    input t_rpt i_rpt_payload
);
    a_stall_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rpt_valid && i_rpt_payload.stall_request |-> i_rpt_payload.now_armed)
        else $error("stall request on a disarmed link");

    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_obs_ready |-> (i_rpt_valid && !i_rpt_ready))
        else $error("input held off without output backpressure");

    a_two_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rpt_valid) |-> $past(i_obs_valid && i_obs_ready, 2))
        else $error("report without a matching transaction two cycles earlier");

    a_rpt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rpt_valid && !i_rpt_ready |=> i_rpt_valid && $stable(i_rpt_payload))
        else $error("stalled report changed");
endmodule

bind link_stall_watchdog_unit lsw_checker u_lsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_obs_valid   (i_obs.valid),
    .i_obs_ready   (i_obs.ready),
    .i_rpt_valid   (o_rpt.valid),
    .i_rpt_ready   (o_rpt.ready),
    .i_rpt_payload (o_rpt.payload)
);

[dv/tb.sv]
// Testbench for link_stall_watchdog_unit: directed and random link status observations,
// with a scoreboard class that predicts each report. Depends on lsw_pkg, lsw_stream_if and link_stall_watchdog_unit.
module tb;
    import lsw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_SLOTS  = 4;
    localparam int CYCLE_LIMIT = 400000;

    class stall_report_board;
        logic [TMO_W-1:0] quiet_timeout;
        logic [ACT_W-1:0] link_count;
        logic             armed[LINK_SLOTS];
        logic [NOW_W-1:0] quiet_start[LINK_SLOTS];
        logic [GEN_W-1:0] seen_gen[LINK_SLOTS];
        t_rpt             pending_reports[$];
        int               failures;

        function new();
            quiet_timeout = QUIET_TIMEOUT_RESET;
            link_count    = ACTIVE_LINKS_RESET;
            failures      = 0;
            for (int i = 0; i < LINK_SLOTS; i++) begin
                armed[i]       = 1'b0;
                quiet_start[i] = '0;
                seen_gen[i]    = '0;
            end
        endfunction

        function void write_reg(t_cfg_reg r, logic [CFG_DAT_W-1:0] d);
            case (r)
                CFG_QUIET_TIMEOUT: quiet_timeout = d;
                CFG_ACTIVE_LINKS:  link_count = d[ACT_W-1:0];
                default: ;
            endcase
        endfunction

        function void fail(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        function void observe_link(t_obs o);
            t_rpt             r;
            int               lim;
            int               k;
            logic [NOW_W-1:0] elapsed;
            lim = (link_count > LINK_SLOTS) ? LINK_SLOTS : link_count;
            k = int'(o.link_index);
            r.report_index  = o.link_index;
            r.stall_request = 1'b0;
            r.now_armed     = armed[k];
            if (k < lim && o.can_reconfigure) begin
                if (!o.link_active || o.link_connected) begin
                    armed[k]       = 1'b0;
                    quiet_start[k] = '0;
                    seen_gen[k]    = o.link_generation;
                end else if (!armed[k] || o.link_generation != seen_gen[k]) begin
                    armed[k]       = 1'b1;
                    quiet_start[k] = o.now_ms;
                    seen_gen[k]    = o.link_generation;
                end else begin
                    elapsed = (o.now_ms >= quiet_start[k]) ? o.now_ms - quiet_start[k] : '0;
                    if (elapsed >= NOW_W'(quiet_timeout)) begin
                        r.stall_request = 1'b1;
                        quiet_start[k]  = o.now_ms;
                    end
                end
                r.now_armed = armed[k];
            end
            pending_reports.push_back(r);
        endfunction

        function void check_report(t_rpt got);
            t_rpt exp;
            if (pending_reports.size() == 0) begin
                fail($sformatf("unexpected report idx=%0d stall=%0b armed=%0b",
                               got.report_index, got.stall_request, got.now_armed));
                return;
            end
            exp = pending_reports.pop_front();
            if (got.report_index !== exp.report_index || got.stall_request !== exp.stall_request
                    || got.now_armed !== exp.now_armed)
                fail($sformatf("report mismatch exp idx=%0d stall=%0b armed=%0b got idx=%0d stall=%0b armed=%0b",
                               exp.report_index, exp.stall_request, exp.now_armed,
                               got.report_index, got.stall_request, got.now_armed));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   idle_mode;
    int   cycle_count;

    logic [NOW_W-1:0] cur_time;
    logic [GEN_W-1:0] link_gen[LINK_SLOTS];

    stall_report_board board;

    lsw_stream_if #(.t_payload(t_obs))    obs_if();
    lsw_stream_if #(.t_payload(t_rpt))    rpt_if();
    lsw_stream_if #(.t_payload(t_cfg_wr)) cfg_if();

    link_stall_watchdog_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (obs_if),
        .o_rpt   (rpt_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        case (idle_mode)
            0:       rpt_if.ready <= ($urandom_range(0, 99) >= 61);
            1:       rpt_if.ready <= ($urandom_range(0, 99) >= 19);
            default: rpt_if.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rpt_if.valid && rpt_if.ready) board.check_report(rpt_if.payload);
    end

    function automatic t_obs mk_obs(logic [IDX_W-1:0] idx, logic [NOW_W-1:0] now, logic rc,
                                    logic act, logic con, logic [GEN_W-1:0] g);
        t_obs o;
        o.link_index      = idx;
        o.now_ms          = now;
        o.can_reconfigure = rc;
        o.link_active     = act;
        o.link_connected  = con;
        o.link_generation = g;
        return o;
    endfunction

    function automatic bit sender_gap();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 19;
            1:       return $urandom_range(0, 99) < 61;
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_obs(input t_obs o);
        while (sender_gap()) begin
            obs_if.valid = 1'b0;
            @(negedge i_clk);
        end
        obs_if.valid   = 1'b1;
        obs_if.payload = o;
        @(posedge i_clk);
        while (!obs_if.ready) @(posedge i_clk);
        board.observe_link(o);
        @(negedge i_clk);
    endtask

    task automatic drain();
        obs_if.valid = 1'b0;
        while (board.pending_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DAT_W-1:0] d);
        drain();
        cfg_if.valid         = 1'b1;
        cfg_if.payload.index = r;
        cfg_if.payload.data  = d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        board.write_reg(r, d);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic random_phase(input logic [TMO_W-1:0] tmo, input int act, input int count);
        int               done;
        int               lim;
        int               r;
        int               idx;
        t_obs             o;
        logic [63:0]      w;
        logic [NOW_W-1:0] adv;
        lim = (act > LINK_SLOTS) ? LINK_SLOTS : act;
        w = {$urandom, $urandom};
        cur_time = w[NOW_W-1:0];
        for (int i = 0; i < LINK_SLOTS; i++) link_gen[i] = $urandom;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 10) begin
                w = {$urandom, $urandom};
                o = mk_obs(IDX_W'($urandom), w[NOW_W-1:0], 1'($urandom), 1'($urandom),
                           1'($urandom), $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    adv = NOW_W'(tmo) + NOW_W'($urandom_range(0, 2));
                else if (r < 15 && tmo != 0)
                    adv = NOW_W'(tmo) - 1;
                else if (r < 85)
                    adv = NOW_W'($urandom_range(0, 40));
                else
                    adv = NOW_W'($urandom_range(0, 5000));
                cur_time = cur_time + adv;
                idx = $urandom_range(0, lim - 1);
                if ($urandom_range(0, 99) < 8) link_gen[idx] = $urandom;
                o = mk_obs(IDX_W'(idx), cur_time, $urandom_range(0, 99) < 94,
                           $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 10,
                           link_gen[idx]);
            end
            done++;
            send_obs(o);
        end
    endtask

    localparam logic [NOW_W-1:0] TIME_MAX = '1;
    localparam logic [TMO_W-1:0] TMO_MAX  = '1;

    logic [TMO_W-1:0] phase_tmo[7] = '{32'd1, 32'd37, 32'd0, TMO_MAX, 32'd12, 32'd5, 32'd300000};
    int               phase_act[7] = '{4, 3, 4, 7, 1, 4, 2};

    initial begin
        board          = new();
        cycle_count    = 0;
        idle_mode      = 0;
        i_rst_n        = 1'b0;
        obs_if.valid   = 1'b0;
        obs_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_obs(mk_obs(0, 0, 1, 1, 0, 0));
        write_reg(CFG_ACTIVE_LINKS, 4);
        write_reg(CFG_QUIET_TIMEOUT, 10);
        send_obs(mk_obs(3, 0, 1, 1, 0, 0));
        send_obs(mk_obs(3, 5, 1, 1, 0, 0));
        send_obs(mk_obs(3, 10, 1, 1, 0, 0));
        send_obs(mk_obs(3, 3, 1, 1, 0, 0));
        send_obs(mk_obs(3, 20, 1, 1, 0, 1));
        send_obs(mk_obs(3, 30, 1, 1, 0, 1));
        send_obs(mk_obs(3, 100, 0, 1, 0, 1));
        send_obs(mk_obs(3, 101, 1, 1, 1, 1));
        send_obs(mk_obs(3, 102, 1, 0, 0, 1));
        send_obs(mk_obs(2, TIME_MAX, 1, 1, 0, '1));
        send_obs(mk_obs(2, TIME_MAX, 1, 1, 0, '1));
        write_reg(CFG_QUIET_TIMEOUT, 0);
        send_obs(mk_obs(2, TIME_MAX, 1, 1, 0, '1));
        send_obs(mk_obs(3, 0, 1, 1, 0, 1));
        send_obs(mk_obs(3, 0, 1, 1, 0, 1));
        write_reg(CFG_ACTIVE_LINKS, 7);
        send_obs(mk_obs(3, 0, 1, 1, 0, 1));
        write_reg(CFG_ACTIVE_LINKS, 2);
        send_obs(mk_obs(3, 1, 1, 1, 0, 1));
        send_obs(mk_obs(1, 1, 1, 1, 0, 5));
        send_obs(mk_obs(1, 2, 1, 1, 1, 5));
        write_reg(CFG_QUIET_TIMEOUT, TMO_MAX);
        write_reg(CFG_ACTIVE_LINKS, 4);
        send_obs(mk_obs(0, 0, 1, 1, 0, 0));
        send_obs(mk_obs(0, NOW_W'(TMO_MAX) - 1, 1, 1, 0, 0));
        send_obs(mk_obs(0, NOW_W'(TMO_MAX), 1, 1, 0, 0));

        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_QUIET_TIMEOUT, phase_tmo[p]);
            write_reg(CFG_ACTIVE_LINKS, phase_act[p]);
            idle_mode = p * 3 / 7;
            random_phase(phase_tmo[p], phase_act[p], 275);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.pending_reports.size() != 0)
            board.fail($sformatf("%0d reports never arrived", board.pending_reports.size()));
        if (board.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
